// ----- design/triangle_bbox_rasterizer_assert.svh -----
// Assertion macros for the triangle rasterizer
`ifndef TRIANGLE_BBOX_RASTERIZER_ASSERT_SVH
`define TRIANGLE_BBOX_RASTERIZER_ASSERT_SVH
`ifndef ASSERT_OFF
`define TBR_ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define TBR_ASSERT_PAST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define TBR_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define TBR_ASSERT_PAST(lbl, clk, rst_n, prop)
`endif
`endif

// ----- design/tbr_pkg.sv -----
`default_nettype none
package tbr_pkg;
  localparam int unsigned ShadeBits = 8;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgDataBits = 12;
  localparam logic [CfgIdxBits-1:0] CfgMaxX = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgMaxY = 1'b1;
  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep = 1'b1;
  localparam logic [CfgDataBits-1:0] MaxReset = 12'd499;
endpackage
`default_nettype wire

// ----- design/tbr_if.sv -----
`default_nettype none
interface tbr_in_if #(parameter int CB = 12);
  logic valid;
  logic ready;
  logic cmd;
  logic signed [CB-1:0] ax, ay, bx, by_coord, cx, cy;
  logic [7:0] shade_in;
  modport source(output valid, cmd, ax, ay, bx, by_coord, cx, cy, shade_in, input ready);
  modport sink(input valid, cmd, ax, ay, bx, by_coord, cx, cy, shade_in, output ready);
endinterface

interface tbr_out_if #(parameter int CB = 12);
  logic valid;
  logic ready;
  logic [CB-1:0] pix_x, pix_y;
  logic hit;
  logic [7:0] shade_out;
  logic last;
  modport source(output valid, pix_x, pix_y, hit, shade_out, last, input ready);
  modport sink(input valid, pix_x, pix_y, hit, shade_out, last, output ready);
endinterface
`default_nettype wire

// ----- design/tbr_queue.sv -----
`default_nettype none
// Two-entry queue between front and back
module tbr_queue #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [W-1:0] in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [W-1:0]      out_data_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wp_q <= ~wp_q;
      if (out_valid_o && out_ready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, in_valid_i && in_ready_o} - {1'b0, out_valid_o && out_ready_i};
    end
  end
endmodule
`default_nettype wire

// ----- design/tbr_front.sv -----
`default_nettype none
// Front: takes start items, latches triangle, forms box and then area in
// setup, then issues pixel tests (x, y, hit-setup, last) in order.
module tbr_front #(
  parameter int CB = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tbr_in_if.sink             in_if,
  input  wire logic [CB-1:0] max_x_i,
  input  wire logic [CB-1:0] max_y_i,
  // pixel job out: {x, y, act, last, shade, ax, ay, e1x, e1y, e2x, e2y, area}
  output logic               job_valid_o,
  input  wire logic          job_ready_i,
  output logic [CB-1:0]      job_x_o,
  output logic [CB-1:0]      job_y_o,
  output logic               job_act_o,
  output logic               job_last_o,
  output logic [7:0]         job_shade_o,
  output logic signed [CB:0] ax_o, ay_o,
  output logic signed [CB:0] e1x_o, e1y_o, e2x_o, e2y_o,
  output logic signed [2*CB+2:0] area_o
);
  localparam int XB = CB + 1;
  logic signed [XB-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic [7:0] sh_q;
  logic [CB-1:0] x0_q, x1_q, y0_q, y1_q, col_q, row_q;
  logic signed [2*CB+2:0] area_q;
  logic act_q;
  logic [1:0] setup_q;
  logic signed [XB-1:0] mnx, mxx, mny, mxy, lx, ly;
  logic signed [XB:0] e1x, e1y, e2x, e2y;
  logic fin;

  function automatic logic signed [XB-1:0] clampv(
      input logic signed [XB-1:0] v, input logic signed [XB-1:0] lim);
    logic signed [XB-1:0] r;
    r = (v < lim) ? v : lim;
    if (r < 0) r = '0;
    return r;
  endfunction

  assign lx = $signed({1'b0, max_x_i});
  assign ly = $signed({1'b0, max_y_i});
  always_comb begin
    mnx = ax_q; if (bx_q < mnx) mnx = bx_q; if (cx_q < mnx) mnx = cx_q;
    mxx = ax_q; if (bx_q > mxx) mxx = bx_q; if (cx_q > mxx) mxx = cx_q;
    mny = ay_q; if (by_q < mny) mny = by_q; if (cy_q < mny) mny = cy_q;
    mxy = ay_q; if (by_q > mxy) mxy = by_q; if (cy_q > mxy) mxy = cy_q;
  end
  assign e1x = XB'(bx_q) - XB'(ax_q);
  assign e1y = by_q - ay_q;
  assign e2x = cx_q - ax_q;
  assign e2y = cy_q - ay_q;

  assign in_if.ready = (setup_q == 2'd0) &&
                       (in_if.cmd == tbr_pkg::CmdStart || job_ready_i);
  assign fin = (col_q == x1_q) && (row_q == y1_q);
  assign job_valid_o = (setup_q == 2'd0) && in_if.valid && in_if.cmd == tbr_pkg::CmdStep;
  assign job_x_o = act_q ? col_q : '0;
  assign job_y_o = act_q ? row_q : '0;
  assign job_act_o = act_q;
  assign job_last_o = act_q ? fin : 1'b1;
  assign job_shade_o = act_q ? sh_q : 8'd0;
  assign ax_o = ax_q;
  assign ay_o = ay_q;
  assign e1x_o = e1x[XB-1:0];
  assign e1y_o = e1y[XB-1:0];
  assign e2x_o = e2x[XB-1:0];
  assign e2y_o = e2y[XB-1:0];
  assign area_o = area_q;

  // Edge deltas fit in CB+1 bits; setup products use the CB+2-bit deltas
  logic signed [2*XB+1:0] p0, p1;
  logic signed [2*XB+1:0] p0_q;
  assign p0 = e2x * e1y;
  assign p1 = e1x * e2y;

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready && in_if.cmd == tbr_pkg::CmdStart) begin
      ax_q <= XB'(in_if.ax); ay_q <= XB'(in_if.ay);
      bx_q <= XB'(in_if.bx); by_q <= XB'(in_if.by_coord);
      cx_q <= XB'(in_if.cx); cy_q <= XB'(in_if.cy);
      sh_q <= in_if.shade_in;
    end
    if (setup_q == 2'd1) begin
      p0_q <= p0;
      x0_q <= CB'(clampv(mnx, lx)); x1_q <= CB'(clampv(mxx, lx));
      y0_q <= CB'(clampv(mny, ly)); y1_q <= CB'(clampv(mxy, ly));
    end
    if (setup_q == 2'd2) begin
      area_q <= (2*CB+3)'(p0_q - p1);
      col_q <= x0_q; row_q <= y0_q;
    end else if (job_valid_o && job_ready_i && act_q && !fin) begin
      if (row_q != y1_q) row_q <= row_q + 1'b1;
      else begin row_q <= y0_q; col_q <= col_q + 1'b1; end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0; setup_q <= 2'd0;
    end else begin
      if (in_if.valid && in_if.ready && in_if.cmd == tbr_pkg::CmdStart) begin
        setup_q <= 2'd1; act_q <= 1'b0;
      end else if (setup_q == 2'd1) setup_q <= 2'd2;
      else if (setup_q == 2'd2) begin setup_q <= 2'd0; act_q <= 1'b1; end
      else if (job_valid_o && job_ready_i && act_q && fin) act_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- design/tbr_back.sv -----
`default_nettype none
// Back: per-pixel coverage test, two stages (products, then signs).
module tbr_back #(
  parameter int CB = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [2*CB+10+6*(CB+1)+2*CB+3-1:0] in_data_i,
  tbr_out_if.source          out_if
);
  localparam int XB = CB + 1;
  localparam int AB = 2 * CB + 3;
  localparam int PB = 2 * XB + 4;
  logic [CB-1:0] x, y;
  logic act, last;
  logic [7:0] sh;
  logic signed [XB-1:0] ax, ay, e1x, e1y, e2x, e2y;
  logic signed [AB-1:0] area;
  assign {x, y, act, last, sh, ax, ay, e1x, e1y, e2x, e2y, area} = in_data_i;

  logic signed [XB+1:0] dx, dy;
  assign dx = $signed({2'b00, x}) - (XB+2)'(ax);
  assign dy = $signed({2'b00, y}) - (XB+2)'(ay);

  // stage 1 registers
  logic v1_q;
  logic signed [PB-1:0] u0a_q, u0b_q, u1a_q, u1b_q;
  logic signed [AB-1:0] ar_q;
  logic [CB-1:0] x1_q, y1_q;
  logic act1_q, last1_q;
  logic [7:0] sh1_q;
  // output register
  logic v2_q;
  logic [CB-1:0] x2_q, y2_q;
  logic hit2_q, last2_q;
  logic [7:0] sh2_q;

  logic adv2, adv1;
  assign adv2 = !v2_q || out_if.ready;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  // u0 = -e1x*dy + dx*e1y ; u1 = -dx*e2y + e2x*dy  (with d = p - a)
  logic signed [PB-1:0] u0, u1, w;
  logic sa;
  logic hit;
  assign u0 = u0a_q - u0b_q;
  assign u1 = u1a_q - u1b_q;
  assign w = PB'(ar_q) - u0 - u1;
  assign sa = ar_q[AB-1];
  always_comb begin
    hit = act1_q && (ar_q != '0);
    if (sa) hit = hit && !(u0 > 0) && !(u1 > 0) && !(w > 0);
    else    hit = hit && !(u0 < 0) && !(u1 < 0) && !(w < 0);
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      u0a_q <= PB'(dx * e1y); u0b_q <= PB'(dy * e1x);
      u1a_q <= PB'(dy * e2x); u1b_q <= PB'(dx * e2y);
      ar_q <= area; x1_q <= x; y1_q <= y; act1_q <= act; last1_q <= last; sh1_q <= sh;
    end
    if (adv2 && v1_q) begin
      x2_q <= x1_q; y2_q <= y1_q; hit2_q <= hit; last2_q <= last1_q; sh2_q <= sh1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  assign out_if.valid = v2_q;
  assign out_if.pix_x = x2_q;
  assign out_if.pix_y = y2_q;
  assign out_if.hit = hit2_q;
  assign out_if.shade_out = sh2_q;
  assign out_if.last = last2_q;
endmodule
`default_nettype wire

// ----- design/triangle_bbox_rasterizer.sv -----
// Triangle rasterizer, bounding box scan with exact barycentric test.
// Step item: result passes through the queue, the product stage and the output reg.
// Throughput: one step per cycle unless the queue is full; a start is followed by setup (box, area), taking no items.
// Reset: asynchronous active low; idle, limits 499, no scan active.
`default_nettype none
`include "triangle_bbox_rasterizer_assert.svh"
module triangle_bbox_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tbr_in_if.sink    in_if,
  tbr_out_if.source out_if,
  input  wire logic cfg_we_i,
  input  wire logic [tbr_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [tbr_pkg::CfgDataBits-1:0] cfg_data_i
);
  localparam int CB = COORD_BITS;
  localparam int XB = CB + 1;
  localparam int AB = 2 * CB + 3;
  localparam int QW = 2*CB + 10 + 6*XB + AB;

  logic [CB-1:0] max_x_q, max_y_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= CB'(tbr_pkg::MaxReset); max_y_q <= CB'(tbr_pkg::MaxReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tbr_pkg::CfgMaxX: max_x_q <= CB'(cfg_data_i);
        tbr_pkg::CfgMaxY: max_y_q <= CB'(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic jv, jr, jact, jlast;
  logic [CB-1:0] jx, jy;
  logic [7:0] jsh;
  logic signed [XB-1:0] ax, ay, e1x, e1y, e2x, e2y;
  logic signed [AB-1:0] area;

  tbr_front #(.CB(CB)) u_front (
    .clk_i, .rst_ni, .in_if,
    .max_x_i(max_x_q), .max_y_i(max_y_q),
    .job_valid_o(jv), .job_ready_i(jr), .job_x_o(jx), .job_y_o(jy),
    .job_act_o(jact), .job_last_o(jlast), .job_shade_o(jsh),
    .ax_o(ax), .ay_o(ay), .e1x_o(e1x), .e1y_o(e1y), .e2x_o(e2x), .e2y_o(e2y),
    .area_o(area)
  );

  logic qv, qr;
  logic [QW-1:0] qd;
  tbr_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni, .in_valid_i(jv), .in_ready_o(jr),
    .in_data_i({jx, jy, jact, jlast, jsh, ax, ay, e1x, e1y, e2x, e2y, area}),
    .out_valid_o(qv), .out_ready_i(qr), .out_data_o(qd)
  );

  tbr_back #(.CB(CB)) u_back (
    .clk_i, .rst_ni, .in_valid_i(qv), .in_ready_o(qr), .in_data_i(qd), .out_if
  );

  // Result payload as one word for the hold check
  logic [2*CB+10-1:0] out_word;
  assign out_word = {out_if.pix_x, out_if.pix_y, out_if.hit, out_if.shade_out, out_if.last};

  `TBR_ASSERT_IMPL(a_hold, clk_i, rst_ni, out_if.valid && !out_if.ready |=> out_if.valid)
  `TBR_ASSERT_IMPL(a_stable, clk_i, rst_ni, out_if.valid && !out_if.ready |=> $stable(out_word))
  `TBR_ASSERT_IMPL(a_cfgx, clk_i, rst_ni, cfg_we_i && cfg_idx_i == tbr_pkg::CfgMaxX |=> max_x_q == $past(CB'(cfg_data_i)))
endmodule
`default_nettype wire
